### design/mms_pkg.sv
// Shared constants and types for the square matrix multiplier.
package mms_pkg;

    localparam int DIMENSION_DEF    = 3;
    localparam int ELEMENT_BITS_DEF = 16;
    localparam int ELEMENT_W        = 16;
    localparam int PRODUCT_W        = 33;
    localparam int INDEX_W          = 2;
    localparam int QUEUE_DEPTH      = 4;

    typedef enum logic [1:0] {
        ST_LOAD = 2'b01,
        ST_CALC = 2'b10
    } t_back_state;

    typedef struct packed {
        logic full;
        logic empty;
    } t_queue_status;

endpackage

### design/mms_front.sv
// Input front end: accepts elements, tags them for matrix A or B and queues them.
module mms_front import mms_pkg::*; #(
    parameter int DIMENSION    = DIMENSION_DEF,
    parameter int ELEMENT_BITS = ELEMENT_BITS_DEF,
    parameter int ENTRY_W      = ELEMENT_BITS + $clog2(DIMENSION * DIMENSION) + 2
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic [ELEMENT_W-1:0] i_element,
    input  t_queue_status        i_queue_status,
    output logic                 o_push,
    output logic [ENTRY_W-1:0]   o_entry
);

    localparam int CELLS  = DIMENSION * DIMENSION;
    localparam int ADDR_W = $clog2(CELLS);
    localparam int CNT_W  = $clog2(2 * CELLS);

    logic [CNT_W-1:0]        r_count;
    logic [CNT_W-1:0]        n_count;
    logic                    w_is_b;
    logic                    w_last;
    logic [ADDR_W-1:0]       w_index;
    logic [ELEMENT_BITS-1:0] w_value;

    assign o_stall = i_queue_status.full;
    assign o_push  = i_valid && !i_queue_status.full;

    assign w_is_b  = (r_count >= CNT_W'(CELLS));
    assign w_last  = (r_count == CNT_W'(2 * CELLS - 1));
    assign w_index = w_is_b ? ADDR_W'(r_count - CNT_W'(CELLS)) : ADDR_W'(r_count);
    assign w_value = ELEMENT_BITS'(i_element);
    assign o_entry = {w_last, w_is_b, w_index, w_value};

    always_comb begin
        n_count = r_count;
        if (o_push) begin
            n_count = w_last ? '0 : r_count + CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

endmodule

### design/mms_queue.sv
// Short FIFO between the front end and the compute engine.
module mms_queue import mms_pkg::*; #(
    parameter int WIDTH = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output t_queue_status    o_status
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = PTR_W + 1;

    logic [WIDTH-1:0] r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    assign o_data         = r_mem[r_rd_ptr];
    assign o_status.full  = (r_count == CNT_W'(QUEUE_DEPTH));
    assign o_status.empty = (r_count == '0);

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (!i_push && i_pop) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && !i_pop && o_status.full))
        else $error("queue written while full");

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_pop && o_status.empty))
        else $error("queue read while empty");

endmodule

### design/mms_back.sv
// Compute engine: matrix stores and a pipelined multiply-accumulate over C = A * B.
module mms_back import mms_pkg::*; #(
    parameter int DIMENSION    = DIMENSION_DEF,
    parameter int ELEMENT_BITS = ELEMENT_BITS_DEF,
    parameter int ENTRY_W      = ELEMENT_BITS + $clog2(DIMENSION * DIMENSION) + 2
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  t_queue_status               i_queue_status,
    input  logic [ENTRY_W-1:0]          i_entry,
    output logic                        o_pop,
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic signed [PRODUCT_W-1:0] o_product_element,
    output logic [INDEX_W-1:0]          o_row_index,
    output logic [INDEX_W-1:0]          o_column_index,
    output logic                        o_last
);

    localparam int CELLS  = DIMENSION * DIMENSION;
    localparam int ADDR_W = $clog2(CELLS);
    localparam int IDX_W  = $clog2(DIMENSION);
    localparam int PROD_W = 2 * ELEMENT_BITS;
    localparam int EXT_W  = (PROD_W > PRODUCT_W) ? PROD_W : PRODUCT_W;

    logic [ELEMENT_BITS-1:0] r_mem_a [CELLS];
    logic [ELEMENT_BITS-1:0] r_mem_b [CELLS];

    t_back_state r_state;
    t_back_state n_state;

    logic [IDX_W-1:0] r_row;
    logic [IDX_W-1:0] r_col;
    logic [IDX_W-1:0] r_k;

    logic                    w_entry_last;
    logic                    w_entry_is_b;
    logic [ADDR_W-1:0]       w_entry_index;
    logic [ELEMENT_BITS-1:0] w_entry_value;

    logic              w_adv;
    logic              w_issue;
    logic              w_k_last;
    logic              w_col_last;
    logic              w_row_last;
    logic              w_final;
    logic [ADDR_W-1:0] w_a_addr;
    logic [ADDR_W-1:0] w_b_addr;

    logic                           r_s1_valid;
    logic                           r_s1_first;
    logic                           r_s1_klast;
    logic                           r_s1_final;
    logic [IDX_W-1:0]               r_s1_row;
    logic [IDX_W-1:0]               r_s1_col;
    logic signed [ELEMENT_BITS-1:0] r_a_q;
    logic signed [ELEMENT_BITS-1:0] r_b_q;

    logic                     r_s2_valid;
    logic                     r_s2_first;
    logic                     r_s2_klast;
    logic                     r_s2_final;
    logic [IDX_W-1:0]         r_s2_row;
    logic [IDX_W-1:0]         r_s2_col;
    logic signed [PROD_W-1:0] r_prod;

    logic signed [EXT_W-1:0] w_prod_ext;
    logic [PRODUCT_W-1:0]    w_sum;
    logic [PRODUCT_W-1:0]    r_acc;

    logic                 r_o_valid;
    logic [PRODUCT_W-1:0] r_o_product;
    logic [INDEX_W-1:0]   r_o_row;
    logic [INDEX_W-1:0]   r_o_col;
    logic                 r_o_last;

    assign {w_entry_last, w_entry_is_b, w_entry_index, w_entry_value} = i_entry;

    assign w_adv      = !r_o_valid || !i_stall;
    assign o_pop      = (r_state == ST_LOAD) && !i_queue_status.empty;
    assign w_issue    = (r_state == ST_CALC) && w_adv;
    assign w_k_last   = (r_k == IDX_W'(DIMENSION - 1));
    assign w_col_last = (r_col == IDX_W'(DIMENSION - 1));
    assign w_row_last = (r_row == IDX_W'(DIMENSION - 1));
    assign w_final    = w_k_last && w_col_last && w_row_last;
    assign w_a_addr   = ADDR_W'(int'(r_row) * DIMENSION + int'(r_k));
    assign w_b_addr   = ADDR_W'(int'(r_k) * DIMENSION + int'(r_col));

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_LOAD: begin
                if (o_pop && w_entry_last) begin
                    n_state = ST_CALC;
                end
            end
            ST_CALC: begin
                if (w_issue && w_final) begin
                    n_state = ST_LOAD;
                end
            end
            default: n_state = ST_LOAD;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_LOAD;
        end else begin
            r_state <= n_state;
        end
    end

    // Store writes during load
    always_ff @(posedge i_clk) begin
        if (o_pop && !w_entry_is_b) begin
            r_mem_a[w_entry_index] <= w_entry_value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && w_entry_is_b) begin
            r_mem_b[w_entry_index] <= w_entry_value;
        end
    end

    // Registered operand reads
    always_ff @(posedge i_clk) begin
        if (w_issue) begin
            r_a_q <= r_mem_a[w_a_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_issue) begin
            r_b_q <= r_mem_b[w_b_addr];
        end
    end

    // Walk row, column and inner index
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row <= '0;
            r_col <= '0;
            r_k   <= '0;
        end else if (o_pop && w_entry_last) begin
            r_row <= '0;
            r_col <= '0;
            r_k   <= '0;
        end else if (w_issue) begin
            if (w_k_last) begin
                r_k <= '0;
                if (w_col_last) begin
                    r_col <= '0;
                    r_row <= w_row_last ? '0 : r_row + IDX_W'(1);
                end else begin
                    r_col <= r_col + IDX_W'(1);
                end
            end else begin
                r_k <= r_k + IDX_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_o_valid  <= 1'b0;
        end else if (w_adv) begin
            r_s1_valid <= w_issue;
            r_s2_valid <= r_s1_valid;
            r_o_valid  <= r_s2_valid && r_s2_klast;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s1_first <= (r_k == '0);
            r_s1_klast <= w_k_last;
            r_s1_final <= w_final;
            r_s1_row   <= r_row;
            r_s1_col   <= r_col;
            r_s2_first <= r_s1_first;
            r_s2_klast <= r_s1_klast;
            r_s2_final <= r_s1_final;
            r_s2_row   <= r_s1_row;
            r_s2_col   <= r_s1_col;
            r_prod     <= r_a_q * r_b_q;
        end
    end

    assign w_prod_ext = EXT_W'(r_prod);
    assign w_sum      = (r_s2_first ? '0 : r_acc) + w_prod_ext[PRODUCT_W-1:0];

    always_ff @(posedge i_clk) begin
        if (w_adv && r_s2_valid) begin
            r_acc <= w_sum;
            if (r_s2_klast) begin
                r_o_product <= w_sum;
                r_o_row     <= INDEX_W'(r_s2_row);
                r_o_col     <= INDEX_W'(r_s2_col);
                r_o_last    <= r_s2_final;
            end
        end
    end

    assign o_valid           = r_o_valid;
    assign o_product_element = $signed(r_o_product);
    assign o_row_index       = r_o_row;
    assign o_column_index    = r_o_col;
    assign o_last            = r_o_last;

    a_last_corner: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_valid && r_o_last) |->
            (r_o_row == INDEX_W'(DIMENSION - 1)) && (r_o_col == INDEX_W'(DIMENSION - 1)))
        else $error("last flag away from the final element");

    a_final_to_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_issue && w_final) |=> (r_state == ST_LOAD))
        else $error("sequencer did not return to load after final term");

endmodule

### design/matrix_multiply_square_unit.sv
// Top level of the square integer matrix multiplier.
//
// Input channel (i_valid, o_stall, i_element): one signed element per beat.
// The first DIMENSION*DIMENSION beats fill A row-major, the next fill B.
// Output channel (o_valid, i_stall, payload): DIMENSION*DIMENSION beats of
// C = A * B in row-major order with row and column indices; o_last marks
// the final element of each product matrix.
// Loading accepts one element per cycle until the four-entry queue fills.
// Once the last B element is stored, the engine runs one multiply-accumulate
// per cycle while the output is not held, DIMENSION^3 per matrix pair,
// through a read, multiply and accumulate pipeline; the first element of C
// appears once its DIMENSION terms have passed those stages. Throughput is
// bounded by the single multiplier and by store writes that wait for the
// final term.
// Elements of the next pair are queued during compute and stored once the
// final term has issued.
// Reset clears the load count, queue and pipeline; store contents are
// undefined until loaded. While the receiver stalls a valid result, the
// result is held and the whole compute pipeline freezes; the queue keeps
// taking input until full, then o_stall rises.
module matrix_multiply_square_unit import mms_pkg::*; #(
    parameter int DIMENSION    = DIMENSION_DEF,
    parameter int ELEMENT_BITS = ELEMENT_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic signed [ELEMENT_W-1:0] i_element,
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic signed [PRODUCT_W-1:0] o_product_element,
    output logic [INDEX_W-1:0]          o_row_index,
    output logic [INDEX_W-1:0]          o_column_index,
    output logic                        o_last
);

    localparam int ENTRY_W = ELEMENT_BITS + $clog2(DIMENSION * DIMENSION) + 2;

    t_queue_status      w_queue_status;
    logic               w_push;
    logic               w_pop;
    logic [ENTRY_W-1:0] w_push_entry;
    logic [ENTRY_W-1:0] w_pop_entry;

    mms_front #(
        .DIMENSION    (DIMENSION),
        .ELEMENT_BITS (ELEMENT_BITS),
        .ENTRY_W      (ENTRY_W)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_element      ($unsigned(i_element)),
        .i_queue_status (w_queue_status),
        .o_push         (w_push),
        .o_entry        (w_push_entry)
    );

    mms_queue #(
        .WIDTH (ENTRY_W)
    ) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_push),
        .i_data   (w_push_entry),
        .i_pop    (w_pop),
        .o_data   (w_pop_entry),
        .o_status (w_queue_status)
    );

    mms_back #(
        .DIMENSION    (DIMENSION),
        .ELEMENT_BITS (ELEMENT_BITS),
        .ENTRY_W      (ENTRY_W)
    ) u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_queue_status    (w_queue_status),
        .i_entry           (w_pop_entry),
        .o_pop             (w_pop),
        .o_valid           (o_valid),
        .i_stall           (i_stall),
        .o_product_element (o_product_element),
        .o_row_index       (o_row_index),
        .o_column_index    (o_column_index),
        .o_last            (o_last)
    );

endmodule

### verif/mms_product_checker.sv
`timescale 1ns / 1ps
// Checker for the square matrix multiplier: watches both channels, predicts each product beat and compares.
module mms_product_checker import mms_pkg::*; #(
    parameter int DIMENSION    = DIMENSION_DEF,
    parameter int ELEMENT_BITS = ELEMENT_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    input  logic                        i_in_stall,
    input  logic signed [ELEMENT_W-1:0] i_element,
    input  logic                        i_out_valid,
    input  logic                        i_out_stall,
    input  logic signed [PRODUCT_W-1:0] i_product_element,
    input  logic [INDEX_W-1:0]          i_row_index,
    input  logic [INDEX_W-1:0]          i_column_index,
    input  logic                        i_last,
    output int                          o_fail_count,
    output int                          o_pending_results
);

    localparam int CELLS      = DIMENSION * DIMENSION;
    localparam int PRINT_SLOTS = 100;

    typedef struct packed {
        logic signed [PRODUCT_W-1:0] value;
        logic [INDEX_W-1:0]          row;
        logic [INDEX_W-1:0]          column;
        logic                        last;
    } t_product_beat;

    logic signed [ELEMENT_BITS-1:0] a_cells [CELLS];
    logic signed [ELEMENT_BITS-1:0] b_cells [CELLS];
    int                             loaded_elements;
    t_product_beat                  product_q [$];
    t_product_beat                  predicted;
    t_product_beat                  oldest;
    longint                         dot_sum;
    int                             fail_total = 0;

    initial begin
        o_fail_count      = 0;
        o_pending_results = 0;
        loaded_elements   = 0;
    end

    task automatic report_mismatch(input string what);
        if (fail_total < PRINT_SLOTS) begin
            $display("[%0t] mismatch: %s", $time, what);
        end
        fail_total++;
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            loaded_elements = 0;
            product_q.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (product_q.size() == 0) begin
                    report_mismatch($sformatf("product beat %0d with nothing pending",
                                              i_product_element));
                end else begin
                    oldest = product_q.pop_front();
                    if (i_product_element !== oldest.value) begin
                        report_mismatch($sformatf("product_element got %0d expected %0d (r%0d c%0d)",
                                                  i_product_element, oldest.value,
                                                  oldest.row, oldest.column));
                    end
                    if (i_row_index !== oldest.row) begin
                        report_mismatch($sformatf("row_index got %0d expected %0d",
                                                  i_row_index, oldest.row));
                    end
                    if (i_column_index !== oldest.column) begin
                        report_mismatch($sformatf("column_index got %0d expected %0d",
                                                  i_column_index, oldest.column));
                    end
                    if (i_last !== oldest.last) begin
                        report_mismatch($sformatf("last got %0b expected %0b (r%0d c%0d)",
                                                  i_last, oldest.last,
                                                  oldest.row, oldest.column));
                    end
                end
            end
            if (i_in_valid && !i_in_stall) begin
                if (loaded_elements < CELLS) begin
                    a_cells[loaded_elements] = i_element[ELEMENT_BITS-1:0];
                end else begin
                    b_cells[loaded_elements - CELLS] = i_element[ELEMENT_BITS-1:0];
                end
                loaded_elements++;
                if (loaded_elements == 2 * CELLS) begin
                    loaded_elements = 0;
                    for (int r = 0; r < DIMENSION; r++) begin
                        for (int c = 0; c < DIMENSION; c++) begin
                            dot_sum = 0;
                            for (int k = 0; k < DIMENSION; k++) begin
                                dot_sum += longint'(a_cells[r * DIMENSION + k]) *
                                           longint'(b_cells[k * DIMENSION + c]);
                            end
                            predicted.value  = dot_sum[PRODUCT_W-1:0];
                            predicted.row    = INDEX_W'(r);
                            predicted.column = INDEX_W'(c);
                            predicted.last   = (r == DIMENSION - 1) && (c == DIMENSION - 1);
                            product_q.push_back(predicted);
                        end
                    end
                end
            end
        end
        o_pending_results <= product_q.size();
        o_fail_count      <= fail_total;
    end

endmodule

### verif/matrix_multiply_square_unit_tb.sv
`timescale 1ns / 1ps
// Testbench top for the square matrix multiplier: element stimulus, result stall and verdict.
module matrix_multiply_square_unit_tb;
    import mms_pkg::*;

    localparam int DIMENSION    = DIMENSION_DEF;
    localparam int CELLS        = DIMENSION * DIMENSION;
    localparam int RANDOM_PAIRS = 23;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 100;
    localparam int CYCLE_LIMIT  = 200000;

    localparam logic signed [ELEMENT_W-1:0] EXTREME_A [CELLS] = '{
        16'sh8000, 16'sh8000, 16'sh8000,
        16'sh7FFF, 16'sh7FFF, 16'sh7FFF,
        16'sh0000, 16'shFFFF, 16'sh0001
    };
    localparam logic signed [ELEMENT_W-1:0] EXTREME_B [CELLS] = '{
        16'sh8000, 16'sh8000, 16'sh8000,
        16'sh8000, 16'sh8000, 16'sh8000,
        16'sh8000, 16'sh8000, 16'sh8000
    };

    logic                        i_clk;
    logic                        i_rst_n   = 1'b0;
    logic                        i_valid   = 1'b0;
    logic                        o_stall;
    logic signed [ELEMENT_W-1:0] i_element = '0;
    logic                        o_valid;
    logic                        i_stall   = 1'b0;
    logic signed [PRODUCT_W-1:0] o_product_element;
    logic [INDEX_W-1:0]          o_row_index;
    logic [INDEX_W-1:0]          o_column_index;
    logic                        o_last;

    int   fail_count;
    int   pending_results;
    int   cycle_count   = 0;
    logic hold_request  = 1'b0;
    logic steady_phase  = 1'b0;

    matrix_multiply_square_unit #(
        .DIMENSION    (DIMENSION),
        .ELEMENT_BITS (ELEMENT_BITS_DEF)
    ) uut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_valid),
        .o_stall           (o_stall),
        .i_element         (i_element),
        .o_valid           (o_valid),
        .i_stall           (i_stall),
        .o_product_element (o_product_element),
        .o_row_index       (o_row_index),
        .o_column_index    (o_column_index),
        .o_last            (o_last)
    );

    mms_product_checker #(
        .DIMENSION    (DIMENSION),
        .ELEMENT_BITS (ELEMENT_BITS_DEF)
    ) product_checker (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_valid),
        .i_in_stall        (o_stall),
        .i_element         (i_element),
        .i_out_valid       (o_valid),
        .i_out_stall       (i_stall),
        .i_product_element (o_product_element),
        .i_row_index       (o_row_index),
        .i_column_index    (o_column_index),
        .i_last            (o_last),
        .o_fail_count      (fail_count),
        .o_pending_results (pending_results)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    task automatic send_element(input logic signed [ELEMENT_W-1:0] value);
        while (!steady_phase && $urandom_range(99) < 13) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid   <= 1'b1;
        i_element <= value;
        do @(posedge i_clk); while (o_stall);
    endtask

    // hold off once for a long stretch so the input queue fills
    initial begin
        forever begin
            @(posedge i_clk);
            if (hold_request) begin
                hold_request <= 1'b0;
                i_stall      <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else begin
                i_stall <= !steady_phase && ($urandom_range(99) < 13);
            end
        end
    end

    initial begin
        int                          pair;
        int                          elem_idx;
        logic                        biased;
        logic signed [ELEMENT_W-1:0] value;

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (elem_idx = 0; elem_idx < CELLS; elem_idx++) begin
            send_element(EXTREME_A[elem_idx]);
        end
        for (elem_idx = 0; elem_idx < CELLS; elem_idx++) begin
            send_element(EXTREME_B[elem_idx]);
        end

        for (pair = 0; pair < RANDOM_PAIRS; pair++) begin
            steady_phase <= (pair >= 12) && (pair < 17);
            if (pair == 4) begin
                hold_request <= 1'b1;
            end
            if (pair == 8 || pair == 20) begin
                i_valid <= 1'b0;
                do @(posedge i_clk); while (pending_results != 0);
            end
            biased = ($urandom_range(3) == 0);
            for (elem_idx = 0; elem_idx < 2 * CELLS; elem_idx++) begin
                if (biased) begin
                    case ($urandom_range(5))
                        0: value = 16'sh8000;
                        1: value = 16'sh7FFF;
                        2: value = '0;
                        3: value = '1;
                        4: value = 16'sh0001;
                        default: value = ELEMENT_W'($urandom_range(16'hFFFF));
                    endcase
                end else begin
                    value = ELEMENT_W'($urandom_range(16'hFFFF));
                end
                send_element(value);
            end
        end

        i_valid <= 1'b0;
        do @(posedge i_clk); while (pending_results != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (fail_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
